// File: rtl/core/pidc_pkg.sv
package pidc_pkg;

  // value and gain formats
  localparam int VAL_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int EL_W       = 16;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int GAIN_SHIFT = 8;
  localparam int MS_PER_S   = 1000;

  // shared multiplier: narrow signed operand times wide signed operand
  localparam int MUL_A_W = EL_W + 1;
  localparam int DER_W   = 43;
  localparam int MUL_B_W = DER_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;

  // serial divider, two quotient bits a cycle
  localparam int DIVD_W    = 48;
  localparam int QS_W      = DIVD_W + 1;
  localparam int DIV_STEPS = DIVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VAL_W;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST     = 16'sd9984;
  localparam logic signed [VAL_W-1:0]  LIMIT_LOW_RST  = -32'sd16711680;
  localparam logic signed [VAL_W-1:0]  LIMIT_HIGH_RST = 32'sd16711680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_TARGET     = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_ERR_EL = 3'd0,
    MUL_DM_K   = 3'd1,
    MUL_GP_ERR = 3'd2,
    MUL_GI_SUM = 3'd3,
    MUL_GD_DER = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_by_el;
    logic     integ_upd;
    logic     der_upd;
    logic     der_zero;
    acc_op_t  acc_op;
    logic     out_load;
  } pidc_cmd_t;

  typedef struct packed {
    logic el_zero;
    logic div_busy;
  } pidc_stat_t;

endpackage

// File: rtl/core/pidc_div.sv
module pidc_div import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [EL_W-1:0]   divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0]    quo;
  logic [DIVD_W-1:0]    quo_mid;
  logic [DIVD_W-1:0]    quo_next;
  logic [EL_W-1:0]      rem;
  logic [EL_W-1:0]      rem_mid;
  logic [EL_W-1:0]      rem_next;
  logic [EL_W-1:0]      dsr;
  logic [DIV_CNT_W-1:0] cnt;

  // one restoring step: dividend bits leave at the top, quotient bits enter below
  function automatic logic [EL_W+DIVD_W-1:0] div_step(input logic [EL_W-1:0] r,
                                                      input logic [DIVD_W-1:0] q,
                                                      input logic [EL_W-1:0] d);
    logic [EL_W:0] t;
    logic [EL_W:0] diff;
    t    = {r, q[DIVD_W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[EL_W-1:0], q[DIVD_W-2:0], 1'b1};
    end else begin
      return {t[EL_W-1:0], q[DIVD_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    {rem_mid, quo_mid}   = div_step(rem, quo, dsr);
    {rem_next, quo_next} = div_step(rem_mid, quo_mid, dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == DIV_CNT_W'(DIV_STEPS))
    else $error("divider did not load its step count");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == DIV_CNT_W'(1) |=> !busy)
    else $error("divider ran past its last step");

endmodule

// File: rtl/core/pidc_dpath.sv
module pidc_dpath import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [VAL_W-1:0] measurement,
  input  logic [EL_W-1:0]         elapsed_ms,
  input  pidc_cmd_t               cmd,
  output pidc_stat_t              stat,
  output logic signed [VAL_W-1:0] drive,
  output logic signed [VAL_W-1:0] drive_negated,
  output logic                    saturated
);

  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;
  logic signed [VAL_W-1:0]   target;
  logic signed [VAL_W-1:0]   limit_low;
  logic signed [VAL_W-1:0]   limit_high;
  logic signed [VAL_W-1:0]   integral;
  logic signed [VAL_W-1:0]   prev;

  logic signed [DIFF_W-1:0]  err;
  logic signed [DIFF_W-1:0]  dm;
  logic [EL_W-1:0]           el;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DER_W-1:0]   der;
  logic signed [ACC_W-1:0]   acc;
  logic                      div_neg;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]         prod_mag;
  logic                      div_busy;
  logic [DIVD_W-1:0]         quotient;
  logic signed [QS_W-1:0]    q_ext;
  logic signed [QS_W-1:0]    q_s;
  logic signed [QS_W-1:0]    sum;
  logic signed [VAL_W-1:0]   sum_c;
  logic signed [ACC_W-1:0]   scaled;
  logic signed [VAL_W-1:0]   drive_c;
  logic signed [VAL_W-1:0]   drive_n;
  logic                      sat_c;

  // configuration, integral and previous measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= GAIN_P_RST;
      gain_i     <= '0;
      gain_d     <= '0;
      target     <= '0;
      limit_low  <= LIMIT_LOW_RST;
      limit_high <= LIMIT_HIGH_RST;
      integral   <= '0;
      prev       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P:     gain_p     <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:     gain_i     <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:     gain_d     <= cfg_data[GAIN_W-1:0];
          REG_TARGET:     target     <= cfg_data;
          REG_LIMIT_LOW:  limit_low  <= cfg_data;
          REG_LIMIT_HIGH: limit_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        prev <= measurement;
      end
      if (cmd.integ_upd) begin
        integral <= sum_c;
      end
    end
  end

  // shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ERR_EL: begin
        mul_a = $signed({1'b0, el});
        mul_b = MUL_B_W'(err);
      end
      MUL_DM_K: begin
        mul_a = MUL_A_W'(MS_PER_S);
        mul_b = MUL_B_W'(dm);
      end
      MUL_GP_ERR: begin
        mul_a = MUL_A_W'(gain_p);
        mul_b = MUL_B_W'(err);
      end
      MUL_GI_SUM: begin
        mul_a = MUL_A_W'(gain_i);
        mul_b = MUL_B_W'(integral);
      end
      MUL_GD_DER: begin
        mul_a = MUL_A_W'(gain_d);
        mul_b = MUL_B_W'(der);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // division on magnitudes, sign put back after: truncation toward zero
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag[DIVD_W-1:0]),
    .divisor  (cmd.div_by_el ? el : EL_W'(MS_PER_S)),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign q_ext = {1'b0, quotient};
  assign q_s   = div_neg ? -q_ext : q_ext;

  // integral clamp, upper limit tested first
  assign sum = QS_W'(integral) + q_s;
  always_comb begin
    if (sum > QS_W'(limit_high)) begin
      sum_c = limit_high;
    end else if (sum < QS_W'(limit_low)) begin
      sum_c = limit_low;
    end else begin
      sum_c = sum[VAL_W-1:0];
    end
  end

  // output: floor scaling by the gain fraction, then the same clamp
  assign scaled = acc >>> GAIN_SHIFT;
  always_comb begin
    sat_c = 1'b1;
    if (scaled > ACC_W'(limit_high)) begin
      drive_c = limit_high;
    end else if (scaled < ACC_W'(limit_low)) begin
      drive_c = limit_low;
    end else begin
      drive_c = scaled[VAL_W-1:0];
      sat_c   = 1'b0;
    end
    drive_n = (drive_c == VAL_MIN) ? VAL_MAX : -drive_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err <= {target[VAL_W-1], target} - {measurement[VAL_W-1], measurement};
      dm  <= {measurement[VAL_W-1], measurement} - {prev[VAL_W-1], prev};
      el  <= elapsed_ms;
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.div_start) begin
      div_neg <= prod[PROD_W-1];
    end
    if (cmd.der_upd) begin
      der <= cmd.der_zero ? '0 : q_s[DER_W-1:0];
    end
    unique case (cmd.acc_op)
      ACC_HOLD: ;
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      ACC_SUB:  acc <= acc - prod;
      default: ;
    endcase
    if (cmd.out_load) begin
      drive         <= drive_c;
      drive_negated <= drive_n;
      saturated     <= sat_c;
    end
  end

  assign stat.el_zero  = (el == '0);
  assign stat.div_busy = div_busy;

  a_integ_in_limits: assert property (@(posedge clk) disable iff (rst)
    cmd.integ_upd |=> (limit_low > limit_high) ||
                      (integral >= limit_low && integral <= limit_high))
    else $error("integral left the clamp range");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while still busy");

endmodule

// File: rtl/core/pidc_ctrl.sv
module pidc_ctrl import pidc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  pidc_stat_t stat,
  output pidc_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE         = 14'b00000000000001,
    S_MUL_INC      = 14'b00000000000010,
    S_DIV_INC_GO   = 14'b00000000000100,
    S_DIV_INC_WAIT = 14'b00000000001000,
    S_INTEG        = 14'b00000000010000,
    S_MUL_DER      = 14'b00000000100000,
    S_DIV_DER_GO   = 14'b00000001000000,
    S_DIV_DER_WAIT = 14'b00000010000000,
    S_DER          = 14'b00000100000000,
    S_MUL_P        = 14'b00001000000000,
    S_MUL_I        = 14'b00010000000000,
    S_MUL_D        = 14'b00100000000000,
    S_ACC_D        = 14'b01000000000000,
    S_FIN          = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL_INC;
        end
      end
      S_MUL_INC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ERR_EL;
        state_next  = S_DIV_INC_GO;
      end
      S_DIV_INC_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_INC_WAIT;
      end
      S_DIV_INC_WAIT: begin
        if (!stat.div_busy) begin
          state_next = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        // no elapsed time: derivative forced to zero, skip its division
        state_next    = stat.el_zero ? S_DER : S_MUL_DER;
      end
      S_MUL_DER: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DM_K;
        state_next  = S_DIV_DER_GO;
      end
      S_DIV_DER_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_by_el = 1'b1;
        state_next    = S_DIV_DER_WAIT;
      end
      S_DIV_DER_WAIT: begin
        if (!stat.div_busy) begin
          state_next = S_DER;
        end
      end
      S_DER: begin
        cmd.der_upd  = 1'b1;
        cmd.der_zero = stat.el_zero;
        state_next   = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GP_ERR;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GI_SUM;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GD_DER;
        cmd.acc_op  = ACC_ADD;
        state_next  = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.acc_op = ACC_SUB;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the item
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_MUL_INC)
    else $error("accepted item did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || !out_stall)
    else $error("output register loaded over a waiting item");

endmodule

// File: rtl/core/pid_controller_clamped_top.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  measurement, elapsed_ms
// out      output     out_valid/out_stall drive, drive_negated, saturated
// cfg      input      cfg_we             cfg_index, cfg_data
//
// most of the time per item goes to the shared radix-4 divider, 24 steps for each
// of its two divisions; the second is skipped when elapsed_ms is zero
// synchronous reset restores gains and limits and clears integral and last measurement
// a result waits in the output register while out_stall is high; the next item is
// taken meanwhile and only its last cycle waits for that register to free
module pid_controller_clamped_top import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] measurement,
  input  logic [EL_W-1:0]         elapsed_ms,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] drive,
  output logic signed [VAL_W-1:0] drive_negated,
  output logic                    saturated
);

  pidc_cmd_t  cmd;
  pidc_stat_t stat;

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .measurement   (measurement),
    .elapsed_ms    (elapsed_ms),
    .cmd           (cmd),
    .stat          (stat),
    .drive         (drive),
    .drive_negated (drive_negated),
    .saturated     (saturated)
  );

endmodule
